// File: hdl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequence checked in the cycle after the antecedent
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/bfas_pkg.sv
// package: constants and codes of the best-fit aligned suballocator
`timescale 1ns / 1ps
package bfas_pkg;
	localparam int BFAS_POOL_LOG2 = 26;
	localparam int BFAS_MAX_SEG   = 64;

	localparam int SIZE_W   = 27;
	localparam int ALIGN_W  = 5;
	localparam int OFFSET_W = 26;
	localparam int STATUS_W = 2;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOFIT   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
	localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd3;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;
endpackage

// File: hdl/bfas_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
module bfas_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: hdl/best_fit_aligned_suballocator_top.sv
// top level of the best-fit aligned suballocator
//   channel  | handshake            | payload
//   request  | in_valid / in_ready  | kind, req_size, align_log2, free_offset
//   result   | out_valid / out_ready| status, offset
// after reset the S_INIT state writes the initial segment, then in_ready rises
// a request is accepted in S_IDLE, scanned in S_SCAN and decided in S_DECIDE
// a successful request then shifts the moved segments in S_SHIFT and writes
// one to three segments in S_WR; S_DONE loads the result
// the single write port of the segment ram sets the cost of moving entries
// a result waits in the output register; a new request is taken once it is loaded
`timescale 1ns / 1ps
module best_fit_aligned_suballocator_top
	import bfas_pkg::*;
#(
	parameter int POOL_BYTES_LOG2 = BFAS_POOL_LOG2,
	parameter int MAX_SEGMENTS    = BFAS_MAX_SEG
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                kind,
	input  logic [SIZE_W-1:0]   req_size,
	input  logic [ALIGN_W-1:0]  align_log2,
	input  logic [OFFSET_W-1:0] free_offset,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STATUS_W-1:0] status,
	output logic [OFFSET_W-1:0] offset
);
	localparam int AW   = POOL_BYTES_LOG2;
	localparam int LW   = AW + 1;
	localparam int CW   = ((AW > 31) ? AW : 31) + 2;
	localparam int IW   = $clog2(MAX_SEGMENTS);
	localparam int CNTW = $clog2(MAX_SEGMENTS + 1);
	localparam int EW   = AW + LW + 1;

	typedef struct packed {
		logic          used;
		logic [LW-1:0] len;
		logic [AW-1:0] start;
	} seg_t;

	typedef enum logic [2:0] {
		S_INIT, S_IDLE, S_SCAN, S_DECIDE, S_SHIFT, S_WR, S_DONE
	} state_t;

	state_t state_q;

	logic            ram_we;
	logic [IW-1:0]   ram_waddr, ram_raddr;
	seg_t            ram_wdata, cur;
	logic [EW-1:0]   ram_rdata;

	logic                kind_q;
	logic [SIZE_W-1:0]   size_q;
	logic [CW-1:0]       amask_q;
	logic [OFFSET_W-1:0] where_q;
	logic [CNTW-1:0]     count_q, new_count_q, rd_q;

	logic                v1_q, v2_q, v3_q;
	logic [IW-1:0]       idx_s1, idx_s2, idx_s3;
	logic [CW-1:0]       al_s2, end_s2, start_s2, al_s3, left_s3, start_s3;
	logic                used_s2, fit_s3;

	logic                found_q;
	logic [IW-1:0]       best_q;
	logic [CW-1:0]       best_left_q, best_al_q, best_start_q;

	logic                ffound_q, grab_q, last_used_q, prv_free_q, nxt_free_q;
	logic [IW-1:0]       fidx_q;
	logic [LW-1:0]       cur_len_q, prv_len_q, nxt_len_q, last_len_q;
	logic [AW-1:0]       prv_start_q, last_start_q;

	logic                sh_up_q, shv_s1;
	logic [CNTW-1:0]     sh_cnt_q, sh_rd_q;
	logic [1:0]          sh_dist_q;
	logic [IW-1:0]       shidx_s1;

	seg_t                lst_q [3];
	logic [1:0]          nlst_q, wcnt_q;
	logic [IW-1:0]       base_q;

	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q, res_status_q;
	logic [OFFSET_W-1:0] offset_q, res_off_q;

	// decision terms
	logic            pre_c, suf_c;
	logic [1:0]      extra_c;
	logic [CW-1:0]   al_end_c, prefix_c;
	logic [CW:0]     d_c;
	logic            prv_c, nxt_c;
	logic [1:0]      rem_c;
	logic [LW-1:0]   merged_c;
	logic [CNTW-1:0] src_c, upn_c;

	bfas_ram #(.WIDTH(EW), .DEPTH(MAX_SEGMENTS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign cur = seg_t'(ram_rdata);

	always_comb begin
		pre_c    = best_al_q != best_start_q;
		suf_c    = best_left_q != '0;
		extra_c  = {1'b0, pre_c} + {1'b0, suf_c};
		prefix_c = best_al_q - best_start_q;
		al_end_c = best_al_q + CW'(size_q);
		d_c      = {1'b0, end_s2} - {1'b0, al_s2} - (CW + 1)'(size_q);
		prv_c    = prv_free_q;
		nxt_c    = nxt_free_q;
		rem_c    = {1'b0, prv_c} + {1'b0, nxt_c};
		merged_c = cur_len_q + (nxt_c ? nxt_len_q : '0) + (prv_c ? prv_len_q : '0);
		src_c    = CNTW'(fidx_q) + CNTW'(1) + CNTW'(nxt_c);
		upn_c    = count_q - CNTW'(best_q) - CNTW'(1);
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		unique case (state_q)
			S_INIT: begin
				ram_we          = 1'b1;
				ram_wdata.len   = LW'(1) << AW;
			end
			S_SHIFT: begin
				ram_we    = shv_s1;
				ram_waddr = sh_up_q ? shidx_s1 + IW'(sh_dist_q) : shidx_s1 - IW'(sh_dist_q);
				ram_wdata = cur;
			end
			S_WR: begin
				ram_we    = 1'b1;
				ram_waddr = base_q + IW'(wcnt_q);
				ram_wdata = lst_q[wcnt_q];
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
		ram_raddr = (state_q == S_SHIFT) ? sh_rd_q[IW-1:0] : rd_q[IW-1:0];
	end

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign offset    = offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_INIT;
			count_q      <= CNTW'(1);
			new_count_q  <= CNTW'(1);
			kind_q       <= KIND_ALLOC;
			size_q       <= '0;
			amask_q      <= '0;
			where_q      <= '0;
			rd_q         <= '0;
			v1_q         <= 1'b0;
			v2_q         <= 1'b0;
			v3_q         <= 1'b0;
			idx_s1       <= '0;
			idx_s2       <= '0;
			idx_s3       <= '0;
			al_s2        <= '0;
			end_s2       <= '0;
			start_s2     <= '0;
			used_s2      <= 1'b0;
			al_s3        <= '0;
			left_s3      <= '0;
			start_s3     <= '0;
			fit_s3       <= 1'b0;
			found_q      <= 1'b0;
			best_q       <= '0;
			best_left_q  <= '0;
			best_al_q    <= '0;
			best_start_q <= '0;
			ffound_q     <= 1'b0;
			grab_q       <= 1'b0;
			last_used_q  <= 1'b0;
			last_len_q   <= '0;
			last_start_q <= '0;
			prv_free_q   <= 1'b0;
			nxt_free_q   <= 1'b0;
			fidx_q       <= '0;
			cur_len_q    <= '0;
			prv_len_q    <= '0;
			nxt_len_q    <= '0;
			prv_start_q  <= '0;
			sh_up_q      <= 1'b0;
			shv_s1       <= 1'b0;
			sh_cnt_q     <= '0;
			sh_rd_q      <= '0;
			sh_dist_q    <= '0;
			shidx_s1     <= '0;
			lst_q        <= '{default: '0};
			nlst_q       <= '0;
			wcnt_q       <= '0;
			base_q       <= '0;
			out_valid_q  <= 1'b0;
			status_q     <= ST_OK;
			offset_q     <= '0;
			res_status_q <= ST_OK;
			res_off_q    <= '0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_INIT: begin
					state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) begin
						kind_q     <= kind;
						size_q     <= req_size;
						amask_q    <= (CW'(1) << align_log2) - CW'(1);
						where_q    <= free_offset;
						rd_q       <= '0;
						found_q    <= 1'b0;
						ffound_q   <= 1'b0;
						grab_q     <= 1'b0;
						prv_free_q <= 1'b0;
						nxt_free_q <= 1'b0;
						state_q    <= S_SCAN;
					end
				end
				S_SCAN: begin
					// read issue
					v1_q   <= rd_q < count_q;
					idx_s1 <= rd_q[IW-1:0];
					if (rd_q < count_q) begin
						rd_q <= rd_q + CNTW'(1);
					end
					// fit arithmetic
					v2_q     <= v1_q;
					idx_s2   <= idx_s1;
					al_s2    <= (CW'(cur.start) + amask_q) & ~amask_q;
					end_s2   <= CW'(cur.start) + CW'(cur.len);
					start_s2 <= CW'(cur.start);
					used_s2  <= cur.used;
					v3_q     <= v2_q;
					idx_s3   <= idx_s2;
					al_s3    <= al_s2;
					start_s3 <= start_s2;
					left_s3  <= d_c[CW-1:0];
					fit_s3   <= !used_s2 && !d_c[CW];
					if (v3_q && fit_s3 && (!found_q || left_s3 < best_left_q)) begin
						found_q      <= 1'b1;
						best_q       <= idx_s3;
						best_left_q  <= left_s3;
						best_al_q    <= al_s3;
						best_start_q <= start_s3;
					end
					// release lookup with neighbor capture
					grab_q <= 1'b0;
					if (v1_q) begin
						last_used_q  <= cur.used;
						last_len_q   <= cur.len;
						last_start_q <= cur.start;
						if (grab_q) begin
							nxt_free_q <= !cur.used;
							nxt_len_q  <= cur.len;
						end
						if (!ffound_q && cur.used && CW'(cur.start) == CW'(where_q)) begin
							ffound_q    <= 1'b1;
							grab_q      <= 1'b1;
							fidx_q      <= idx_s1;
							cur_len_q   <= cur.len;
							prv_free_q  <= (idx_s1 != '0) && !last_used_q;
							prv_len_q   <= last_len_q;
							prv_start_q <= last_start_q;
						end
					end
					if (rd_q == count_q && !v1_q && !v2_q && !v3_q) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					wcnt_q  <= '0;
					shv_s1  <= 1'b0;
					res_off_q <= '0;
					if (kind_q == KIND_ALLOC) begin
						if (size_q == '0 || !found_q) begin
							res_status_q <= ST_NOFIT;
							state_q      <= S_DONE;
						end else if ({1'b0, count_q} + (CNTW + 1)'(extra_c)
								> (CNTW + 1)'(MAX_SEGMENTS)) begin
							res_status_q <= ST_FULL;
							state_q      <= S_DONE;
						end else begin
							res_status_q <= ST_OK;
							res_off_q    <= best_al_q[OFFSET_W-1:0];
							new_count_q  <= count_q + CNTW'(extra_c);
							base_q       <= best_q;
							nlst_q       <= extra_c + 2'd1;
							if (pre_c) begin
								lst_q[0] <= '{used: 1'b0, len: LW'(prefix_c),
									start: AW'(best_start_q)};
								lst_q[1] <= '{used: 1'b1, len: LW'(size_q),
									start: AW'(best_al_q)};
								lst_q[2] <= '{used: 1'b0, len: LW'(best_left_q),
									start: AW'(al_end_c)};
							end else begin
								lst_q[0] <= '{used: 1'b1, len: LW'(size_q),
									start: AW'(best_al_q)};
								lst_q[1] <= '{used: 1'b0, len: LW'(best_left_q),
									start: AW'(al_end_c)};
								lst_q[2] <= '0;
							end
							sh_up_q   <= 1'b1;
							sh_dist_q <= extra_c;
							sh_rd_q   <= count_q - CNTW'(1);
							sh_cnt_q  <= (extra_c == '0) ? '0 : upn_c;
							state_q   <= S_SHIFT;
						end
					end else begin
						if (!ffound_q) begin
							res_status_q <= ST_UNKNOWN;
							state_q      <= S_DONE;
						end else begin
							res_status_q <= ST_OK;
							new_count_q  <= count_q - CNTW'(rem_c);
							base_q       <= prv_c ? fidx_q - IW'(1) : fidx_q;
							nlst_q       <= 2'd1;
							lst_q[0]     <= '{used: 1'b0, len: merged_c,
								start: prv_c ? prv_start_q : AW'(where_q)};
							sh_up_q      <= 1'b0;
							sh_dist_q    <= rem_c;
							sh_rd_q      <= src_c;
							sh_cnt_q     <= (rem_c == '0 || src_c >= count_q) ? '0
								: count_q - src_c;
							state_q      <= S_SHIFT;
						end
					end
				end
				S_SHIFT: begin
					shv_s1   <= sh_cnt_q != '0;
					shidx_s1 <= sh_rd_q[IW-1:0];
					if (sh_cnt_q != '0) begin
						sh_cnt_q <= sh_cnt_q - CNTW'(1);
						sh_rd_q  <= sh_up_q ? sh_rd_q - CNTW'(1) : sh_rd_q + CNTW'(1);
					end else if (!shv_s1) begin
						state_q <= S_WR;
					end
				end
				S_WR: begin
					wcnt_q <= wcnt_q + 2'd1;
					if (wcnt_q + 2'd1 == nlst_q) begin
						count_q <= new_count_q;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						status_q    <= res_status_q;
						offset_q    <= res_off_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

// File: hdl/bfas_checker.sv
// port checker for the best-fit aligned suballocator, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bfas_checker
	import bfas_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                kind,
	input logic [SIZE_W-1:0]   req_size,
	input logic [ALIGN_W-1:0]  align_log2,
	input logic [OFFSET_W-1:0] free_offset,
	input logic                out_valid,
	input logic                out_ready,
	input logic [STATUS_W-1:0] status,
	input logic [OFFSET_W-1:0] offset
);
	// a stalled result holds
	`CHK_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(status) && $stable(offset), "result changed while stalled")
	// failures carry a zero offset
	`CHK_IMPL(a_fail_zero, clk, arst_n, out_valid && status != ST_OK,
		offset == '0, "failed request with nonzero offset")
	// one request at a time
	`CHK_NEXT(a_one_item, clk, arst_n, in_valid && in_ready,
		!in_ready, "request taken while busy")
	// a new result is loaded only while the block is busy
	`CHK_IMPL(a_result_source, clk, arst_n, $rose(out_valid),
		$past(!in_ready), "result without a pending request")
endmodule

bind best_fit_aligned_suballocator_top bfas_checker u_bfas_checker (.*);
